### hdl/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/nggp_pkg.sv
// package for the gga position parser: constants, codes, item types
// no dependencies
package nggp_pkg;

  localparam int LINE_CHARS  = 128;
  localparam int FIELD_CHARS = 24;
  localparam int FRAC_DIGITS = 4;
  localparam int QDEPTH      = 2;

  localparam logic [6:0] LINE_LAST  = 7'(LINE_CHARS - 1);
  localparam logic [4:0] FIELD_LAST = 5'(FIELD_CHARS - 1);

  localparam logic [3:0] HDR_DONE = 4'd6;
  localparam logic [3:0] HDR_NUL  = 4'd7;
  localparam logic [3:0] HDR_FAIL = 4'd15;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_GGA   = 3'd1;
  localparam logic [2:0] ST_FEW_FIELD = 3'd2;
  localparam logic [2:0] ST_BAD_LAT   = 3'd3;
  localparam logic [2:0] ST_BAD_LON   = 3'd4;

  localparam logic [6:0] DIV_DEG = 7'd100;
  localparam logic [6:0] DIV_3   = 7'd3;

  // reciprocals: x/100 = (x*MAGIC_100)>>37, x/3 = (x*MAGIC_3)>>33, exact for 32-bit x
  localparam logic [31:0] MAGIC_100 = 32'h51EB851F;
  localparam logic [31:0] MAGIC_3   = 32'hAAAAAAAB;

  typedef struct packed {
    logic [31:0] whole;
    logic [13:0] frac;
    logic [5:0]  marks;
  } coord_t;

  typedef struct packed {
    logic [31:0] whole;
    logic [13:0] frac;
    logic        ok;
    logic        neg;
  } conv_t;

  typedef struct packed {
    logic  hdr_ok;
    logic  fields_ok;
    conv_t lat;
    conv_t lon;
  } job_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = "$";
      3'd1:    r = "G";
      3'd2:    r = "N";
      3'd3:    r = "G";
      3'd4:    r = "G";
      3'd5:    r = "A";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/nggp_fifo.sv
// short queue of parsed lines between front and back
// depends on nggp_pkg
module nggp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  nggp_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output nggp_pkg::job_t rdata_o,
  output logic          empty_o
);
  import nggp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t         mem_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      case ({wr_i && !full_o, rd_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

### hdl/nggp_div.sv
// unsigned divide by 100 or by 3 through reciprocal multiplication with a registered product
// depends on nggp_pkg
module nggp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [6:0]  rem_o
);
  import nggp_pkg::*;

  logic [31:0] x_q;
  logic [6:0]  dvs_q;
  logic        by3_q;
  logic [63:0] prod_q;
  logic        mul_q, done_q;
  logic [31:0] magic;
  logic [31:0] back;

  assign magic  = by3_q ? MAGIC_3 : MAGIC_100;
  assign quot_o = by3_q ? {1'b0, prod_q[63:33]} : {5'd0, prod_q[63:37]};
  assign back   = 32'(quot_o * {25'd0, dvs_q});
  assign rem_o  = 7'(x_q - back);
  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      dvs_q <= divisor_i;
      by3_q <= (divisor_i == DIV_3);
    end
    if (mul_q) prod_q <= 64'(x_q) * 64'(magic);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      done_q <= mul_q && !start_i;
    end
  end
endmodule

### hdl/nggp_front.sv
// front end: line framing, header match, field split, digit accumulation
// depends on nggp_pkg
module nggp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     rx_byte_i,
  output logic           job_wr_o,
  output nggp_pkg::job_t job_o
);
  import nggp_pkg::*;

  logic       in_line_q, in_line_d;
  logic [6:0] len_q, len_d;
  logic [3:0] hdr_q, hdr_d;
  logic [2:0] fnum_q, fnum_d;
  logic [4:0] flen_q, flen_d;
  coord_t     lat_q, lat_d, lon_q, lon_d;
  logic [7:0] lath_q, lath_d, lonh_q, lonh_d;
  logic       line_end;

  function automatic logic [13:0] frac_weight(input logic [1:0] cnt);
    logic [13:0] w;
    case (cnt)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic coord_t coord_step(input coord_t cur, input logic [7:0] c);
    coord_t     r;
    logic       digit;
    logic [3:0] d;
    logic [2:0] cnt;
    r     = cur;
    digit = (c >= "0") && (c <= "9");
    d     = 4'(c - "0");
    r.marks[0] = 1'b1;
    if (!r.marks[2]) begin
      if (!r.marks[1]) begin
        if (c == ".") r.marks[1] = 1'b1;
        else if (digit) r.whole = {r.whole[28:0], 3'b0} + {r.whole[30:0], 1'b0}
                                  + {28'd0, d};
        else r.marks[2] = 1'b1;
      end else begin
        cnt = r.marks[5:3];
        if (cnt < 3'(FRAC_DIGITS) && cnt < 3'd4) begin
          if (digit) begin
            r.frac = r.frac + 14'(d * frac_weight(cnt[1:0]));
            cnt    = cnt + 1'b1;
          end else begin
            cnt = 3'(FRAC_DIGITS);
          end
          r.marks[5:3] = cnt;
        end
      end
    end
    return r;
  endfunction

  function automatic logic hemi_neg(input logic [7:0] h);
    return (h == "S") || (h == "s") || (h == "W") || (h == "w");
  endfunction

  always_comb begin
    in_line_d = in_line_q;
    len_d     = len_q;
    hdr_d     = hdr_q;
    fnum_d    = fnum_q;
    flen_d    = flen_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    lath_d    = lath_q;
    lonh_d    = lonh_q;
    line_end  = 1'b0;
    if (accept_i) begin
      if (!in_line_q) begin
        if (rx_byte_i == "$") begin
          in_line_d = 1'b1;
          len_d     = 7'd1;
          hdr_d     = 4'd1;
          fnum_d    = '0;
          flen_d    = '0;
          lat_d     = '0;
          lon_d     = '0;
          lath_d    = '0;
          lonh_d    = '0;
        end
      end else begin
        if (hdr_q < HDR_DONE) begin
          hdr_d = ((len_q == {3'd0, hdr_q}) && ((rx_byte_i == hdr_char(hdr_q[2:0])) ||
                   (hdr_q == 4'd2 && rx_byte_i == "P"))) ? hdr_q + 1'b1 : HDR_FAIL;
        end else if (hdr_q == HDR_DONE) begin
          if (rx_byte_i == 8'd0) begin
            hdr_d = HDR_NUL;
          end else if (rx_byte_i == ",") begin
            if (fnum_q < 3'd6) fnum_d = fnum_q + 1'b1;
            flen_d = '0;
          end else if (flen_q < FIELD_LAST) begin
            case (fnum_q)
              3'd2:    lat_d = coord_step(lat_q, rx_byte_i);
              3'd3:    if (flen_q == '0) lath_d = rx_byte_i;
              3'd4:    lon_d = coord_step(lon_q, rx_byte_i);
              3'd5:    if (flen_q == '0) lonh_d = rx_byte_i;
              default: ;
            endcase
            flen_d = flen_q + 1'b1;
          end
        end
        len_d = len_q + 1'b1;
        if (rx_byte_i == 8'h0d || rx_byte_i == 8'h0a || len_d >= LINE_LAST) begin
          line_end  = 1'b1;
          in_line_d = 1'b0;
        end
      end
    end
  end

  assign job_wr_o         = line_end;
  assign job_o.hdr_ok     = (hdr_d == HDR_DONE) || (hdr_d == HDR_NUL);
  assign job_o.fields_ok  = (fnum_d >= 3'd5);
  assign job_o.lat.whole  = lat_d.whole;
  assign job_o.lat.frac   = lat_d.frac;
  assign job_o.lat.ok     = lat_d.marks[0] && !lat_d.marks[2];
  assign job_o.lat.neg    = hemi_neg(lath_d);
  assign job_o.lon.whole  = lon_d.whole;
  assign job_o.lon.frac   = lon_d.frac;
  assign job_o.lon.ok     = lon_d.marks[0] && !lon_d.marks[2];
  assign job_o.lon.neg    = hemi_neg(lonh_d);

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    hdr_q  <= hdr_d;
    fnum_q <= fnum_d;
    flen_q <= flen_d;
    lat_q  <= lat_d;
    lon_q  <= lon_d;
    lath_q <= lath_d;
    lonh_q <= lonh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_line_q <= 1'b0;
    else         in_line_q <= in_line_d;
  end
endmodule

### hdl/nggp_back.sv
// back end: status decision and ddmm.mmmm to microdegree conversion
// depends on nggp_pkg and nggp_div
module nggp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  nggp_pkg::job_t job_i,
  output logic           job_rd_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [2:0]     status_o,
  output logic [31:0]    lat_micro_o,
  output logic [31:0]    lon_micro_o
);
  import nggp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_DEG, S_MUL, S_S3, S_D3, S_EMIT
  } state_e;

  state_e      state_q;
  job_t        job_q;
  logic        coord_q, dneg_q;
  logic [2:0]  st_q;
  logic [31:0] deg_q, num_q, prod_q, latres_q;
  logic [31:0] v_fin_hold_q;
  logic [7:0]  mn_q;
  logic        oval_q;
  logic [2:0]  ost_q;
  logic [31:0] olat_q, olon_q;

  logic        div_start, div_done, div_neg;
  logic [31:0] div_dvd, div_quot;
  logic [6:0]  div_dvs, div_rem;
  conv_t       cur;
  logic [31:0] q_signed, v_pos, v_fin, num_nxt;
  logic        load_out;

  assign cur      = coord_q ? job_q.lon : job_q.lat;
  assign q_signed = dneg_q ? 32'd0 - div_quot : div_quot;
  assign v_pos    = prod_q + q_signed;
  assign v_fin    = cur.neg ? 32'd0 - v_pos : v_pos;
  assign num_nxt  = 32'($signed(mn_q) * 32'sd50000) + 32'({18'd0, cur.frac} * 32'd5);
  assign load_out = (state_q == S_EMIT) && (!oval_q || pop_i);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DIV_DEG;
    div_neg   = 1'b0;
    case (state_q)
      S_CHK: begin
        div_start = job_q.hdr_ok && job_q.fields_ok && job_q.lat.ok;
        div_dvd   = job_q.lat.whole[31] ? 32'd0 - job_q.lat.whole : job_q.lat.whole;
        div_neg   = job_q.lat.whole[31];
      end
      S_D3: begin
        div_start = div_done && !coord_q && job_q.lon.ok;
        div_dvd   = job_q.lon.whole[31] ? 32'd0 - job_q.lon.whole : job_q.lon.whole;
        div_neg   = job_q.lon.whole[31];
      end
      S_S3: begin
        div_start = 1'b1;
        div_dvd   = num_q[31] ? 32'd0 - num_q : num_q;
        div_dvs   = DIV_3;
        div_neg   = num_q[31];
      end
      default: ;
    endcase
  end

  nggp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign job_rd_o    = (state_q == S_IDLE) && !job_empty_i;
  assign empty_o     = !oval_q;
  assign status_o    = ost_q;
  assign lat_micro_o = olat_q;
  assign lon_micro_o = olon_q;

  always_ff @(posedge clk_i) begin
    if (job_rd_o) job_q <= job_i;
    if (div_start) dneg_q <= div_neg;
    case (state_q)
      S_DEG: if (div_done) begin
        deg_q <= q_signed;
        mn_q  <= dneg_q ? 8'd0 - {1'b0, div_rem} : {1'b0, div_rem};
      end
      S_MUL: begin
        num_q  <= num_nxt;
        prod_q <= 32'(deg_q * 32'd1000000);
      end
      // latitude kept, longitude held until the output slot frees
      S_D3: if (div_done) begin
        if (!coord_q) latres_q <= v_fin;
        else          v_fin_hold_q <= v_fin;
      end
      default: ;
    endcase
    if (load_out) begin
      ost_q  <= st_q;
      olat_q <= (st_q == ST_OK) ? latres_q : '0;
      olon_q <= (st_q == ST_OK) ? v_fin_hold_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      coord_q <= 1'b0;
      st_q    <= ST_OK;
      oval_q  <= 1'b0;
    end else begin
      if (load_out)        oval_q <= 1'b1;
      else if (pop_i)      oval_q <= 1'b0;
      case (state_q)
        S_IDLE: if (!job_empty_i) begin
          state_q <= S_CHK;
          coord_q <= 1'b0;
        end
        S_CHK: begin
          if (!job_q.hdr_ok) begin
            st_q    <= ST_NOT_GGA;
            state_q <= S_EMIT;
          end else if (!job_q.fields_ok) begin
            st_q    <= ST_FEW_FIELD;
            state_q <= S_EMIT;
          end else if (!job_q.lat.ok) begin
            st_q    <= ST_BAD_LAT;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_DEG;
          end
        end
        S_DEG:   if (div_done) state_q <= S_MUL;
        S_MUL:   state_q <= S_S3;
        S_S3:    state_q <= S_D3;
        S_D3: if (div_done) begin
          if (coord_q) begin
            st_q    <= ST_OK;
            state_q <= S_EMIT;
          end else if (!job_q.lon.ok) begin
            st_q    <= ST_BAD_LON;
            state_q <= S_EMIT;
          end else begin
            coord_q <= 1'b1;
            state_q <= S_DEG;
          end
        end
        S_EMIT:  if (load_out) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/nmea_gga_position_parser.sv
// top level of the gga position parser: front end, line queue, back end
// depends on nggp_pkg, nggp_front, nggp_fifo, nggp_back
// takes one receiver byte per accepted item and, on each byte that closes a
// line ('$' opens it; CR, LF or the 127th character closes it), delivers one
// item with a status and latitude/longitude in microdegrees. the front end
// takes a byte every cycle; a finished line goes into a two-deep queue and
// full rises only while that queue is full, then holds off every byte. the
// back end divides by 100 and by 3 through reciprocal multiplication; each
// coordinate steps through S_DEG, S_MUL, S_S3 and S_D3 on its way from the
// queue to the result slot, and a line failing on header, field count or
// latitude goes from S_CHK to S_EMIT, one failing on longitude after the
// latitude steps. a result that is not popped holds the back end in its last
// step, so input stalls only once two lines are already waiting behind it.
module nmea_gga_position_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [31:0] lat_micro_o,
  output logic [31:0] lon_micro_o
);
  import nggp_pkg::*;

  logic accept;
  logic job_wr, job_rd, job_empty;
  job_t job_in, job_out;

  // a byte is taken whenever the queue has room for a possible line end
  assign accept = push && !full;

  nggp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .job_wr_o  (job_wr),
    .job_o     (job_in)
  );

  nggp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_in),
    .full_o  (full),
    .rd_i    (job_rd),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  nggp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_rd_o    (job_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .status_o    (status_o),
    .lat_micro_o (lat_micro_o),
    .lon_micro_o (lon_micro_o)
  );
endmodule

### hdl/nggp_checker.sv
// port-level checks for the gga position parser, bound to the top level
// depends on assert_macros.svh and nggp_pkg
`include "assert_macros.svh"
module nggp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [31:0] lat_micro_o,
  input logic [31:0] lon_micro_o
);
  import nggp_pkg::*;

  logic        fail_shown, coord_zero, waiting;
  logic [66:0] shown;

  assign fail_shown = !empty && (status_o != ST_OK);
  assign coord_zero = (lat_micro_o == 32'd0) && (lon_micro_o == 32'd0);
  assign waiting    = !empty && !pop;
  assign shown      = {status_o, lat_micro_o, lon_micro_o};

  `CHK_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> empty, "item shown during reset")
  `CHK_ASSERT(a_status_range, clk_i, rst_ni, !empty |-> status_o <= ST_BAD_LON, "bad status")
  `CHK_ASSERT(a_fail_zero, clk_i, rst_ni, fail_shown |-> coord_zero, "coords on failed line")
  `CHK_ASSERT(a_hold, clk_i, rst_ni, waiting |=> (!empty && $stable(shown)), "item changed")
endmodule

bind nmea_gga_position_parser nggp_checker u_nggp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .status_o    (status_o),
  .lat_micro_o (lat_micro_o),
  .lon_micro_o (lon_micro_o)
);
